/* rtl/tsjm_pkg.sv */
// Shared types, codes and sizes for the typed slot join matcher.
`timescale 1ns / 1ps
`default_nettype none

package tsjm_pkg;

	// Sizes
	localparam int TABLE_DEPTH     = 64;
	localparam int MAX_PINS_DEF    = 64;
	localparam int CODE_BITS_DEF   = 16;
	localparam int HANDLE_BITS_DEF = 32;

	// Request actions
	localparam logic [1:0] ACT_DEFINE  = 2'd0;
	localparam logic [1:0] ACT_ADD     = 2'd1;
	localparam logic [1:0] ACT_REMOVE  = 2'd2;
	localparam logic [1:0] ACT_NEWSOCK = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// One request as it arrives on the ports
	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  kind;
		logic [15:0] type_code;
		logic [15:0] subtype_code;
		logic [31:0] handle;
	} tsjm_req_t;

	// One result as it leaves on the ports
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  pin_hit;
		logic [31:0] handle_out;
		logic        active;
		logic        empty_res;
	} tsjm_res_t;

	// Request token handed from cell to cell along the chain
	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  kind;
		logic [15:0] type_code;
		logic [15:0] subtype_code;
		logic [31:0] handle;      // add: handle to store; remove: handle taken
		logic        done;        // a cell has claimed this request
		logic [1:0]  status;
		logic [5:0]  hit;         // define: target pin; add/remove: claimed pin
		logic        all_filled;  // every socket pin so far is filled
		logic        any_filled;  // some socket pin so far is filled
	} tsjm_tok_t;

endpackage

`default_nettype wire

/* rtl/tsjm_cell.sv */
// One pin cell: holds a pin pattern, its filled flag and handle, and passes the token on.
`timescale 1ns / 1ps
`default_nettype none

module tsjm_cell
	import tsjm_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = CODE_BITS_DEF,
	parameter int HW    = HANDLE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tok_valid_in,
	input  wire tsjm_tok_t tok_in,
	output logic           tok_valid_out,
	output tsjm_tok_t      tok_out
);

	logic [1:0]    kind_q;
	logic [CW-1:0] type_q;
	logic [CW-1:0] sub_q;
	logic [HW-1:0] handle_q;
	logic          defined_q;
	logic          in_sock_q;
	logic          filled_q;

	logic          defined_d;
	logic          in_sock_d;
	logic          filled_d;
	logic          wr_pat;
	logic          wr_hnd;
	logic          match;
	tsjm_tok_t     tok_d;

	// Pattern compare against the passing request
	assign match = in_sock_q && (kind_q == tok_in.kind) &&
		(type_q == tok_in.type_code[CW-1:0]) &&
		(sub_q == tok_in.subtype_code[CW-1:0]);

	// Per-cell action and token update
	always_comb begin
		tok_d     = tok_in;
		defined_d = defined_q;
		in_sock_d = in_sock_q;
		filled_d  = filled_q;
		wr_pat    = 1'b0;
		wr_hnd    = 1'b0;
		if (tok_valid_in) begin
			case (tok_in.action)
				ACT_DEFINE: begin
					if (tok_in.status == ST_OK && tok_in.hit == 6'(INDEX)) begin
						defined_d = 1'b1;
						wr_pat    = 1'b1;
					end
				end
				ACT_ADD: begin
					if (!tok_in.done && match && !filled_q) begin
						filled_d     = 1'b1;
						wr_hnd       = 1'b1;
						tok_d.done   = 1'b1;
						tok_d.status = ST_OK;
						tok_d.hit    = 6'(INDEX);
					end
				end
				ACT_REMOVE: begin
					if (!tok_in.done && match && filled_q) begin
						filled_d     = 1'b0;
						tok_d.done   = 1'b1;
						tok_d.status = ST_OK;
						tok_d.hit    = 6'(INDEX);
						tok_d.handle = 32'(handle_q);
					end
				end
				ACT_NEWSOCK: begin
					filled_d  = 1'b0;
					in_sock_d = defined_q;
				end
				default: begin
				end
			endcase
		end
		// Socket-wide flags gather the state left behind in this cell
		if (in_sock_d) begin
			tok_d.all_filled = tok_in.all_filled & filled_d;
			tok_d.any_filled = tok_in.any_filled | filled_d;
		end
	end

	// Control and pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_out <= 1'b0;
			defined_q     <= 1'b0;
			in_sock_q     <= 1'b0;
			filled_q      <= 1'b0;
			kind_q        <= '0;
			type_q        <= '0;
			sub_q         <= '0;
		end else begin
			tok_valid_out <= tok_valid_in;
			defined_q     <= defined_d;
			in_sock_q     <= in_sock_d;
			filled_q      <= filled_d;
			if (wr_pat) begin
				kind_q <= tok_in.kind;
				type_q <= tok_in.type_code[CW-1:0];
				sub_q  <= tok_in.subtype_code[CW-1:0];
			end
		end
	end

	// Token payload and stored handle
	always_ff @(posedge clk) begin
		tok_out <= tok_d;
		if (wr_hnd) begin
			handle_q <= tok_in.handle[HW-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/typed_slot_join_matcher.sv */
// Top level: request entry, pin count and the chain of pin cells.
// Each request passes down the chain of registered pin cells before its result appears at the tail.
// Throughput: one request per cycle; each request walks the pin chain one cell at a time.
// busy stays low, so a request may follow in every cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous): pin table empty, socket width zero, nothing filled.
// Results come out strictly in request order, one strobe per request.
`timescale 1ns / 1ps
`default_nettype none

module typed_slot_join_matcher
	import tsjm_pkg::*;
#(
	parameter int MAX_PINS    = MAX_PINS_DEF,
	parameter int CODE_BITS   = CODE_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire tsjm_req_t req,
	output logic           done,
	output tsjm_res_t      res
);

	localparam int CW    = (CODE_BITS < 16) ? CODE_BITS : 16;
	localparam int HW    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
	localparam int CNT_W = $clog2(MAX_PINS + 1);

	logic [CNT_W-1:0] pin_total_q;
	logic             accept;
	logic             full;
	tsjm_tok_t        tok_entry;

	logic      tok_valid [0:MAX_PINS];
	tsjm_tok_t tok       [0:MAX_PINS];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (pin_total_q == CNT_W'(MAX_PINS));

	// Pin count: a define is placed here, before it enters the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_total_q <= '0;
		end else if (accept && req.action == ACT_DEFINE && !full) begin
			pin_total_q <= pin_total_q + CNT_W'(1);
		end
	end

	// Build the entry token
	always_comb begin
		tok_entry.action        = req.action;
		tok_entry.kind          = req.kind;
		tok_entry.type_code     = 16'(req.type_code[CW-1:0]);
		tok_entry.subtype_code  = 16'(req.subtype_code[CW-1:0]);
		tok_entry.handle        = (req.action == ACT_ADD) ? 32'(req.handle[HW-1:0]) : '0;
		tok_entry.done          = 1'b0;
		tok_entry.status        = ST_OK;
		tok_entry.hit           = '0;
		tok_entry.all_filled    = 1'b1;
		tok_entry.any_filled    = 1'b0;
		case (req.action)
			ACT_DEFINE: begin
				if (full) begin
					tok_entry.status = ST_FULL;
				end else begin
					tok_entry.hit = 6'(pin_total_q);
				end
			end
			ACT_ADD, ACT_REMOVE: begin
				tok_entry.status = ST_NOMATCH;
			end
			default: begin
			end
		endcase
	end

	assign tok_valid[0] = accept;
	assign tok[0]       = tok_entry;

	// Chain of pin cells
	for (genvar i = 0; i < MAX_PINS; i++) begin : g_cell
		tsjm_cell #(
			.INDEX (i),
			.CW    (CW),
			.HW    (HW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.tok_valid_in  (tok_valid[i]),
			.tok_in        (tok[i]),
			.tok_valid_out (tok_valid[i+1]),
			.tok_out       (tok[i+1])
		);
	end

	// Result from the chain tail
	always_comb begin
		done           = tok_valid[MAX_PINS];
		res.status     = tok[MAX_PINS].status;
		res.pin_hit    = tok[MAX_PINS].hit;
		res.handle_out = (tok[MAX_PINS].action == ACT_REMOVE) ? tok[MAX_PINS].handle : '0;
		res.active     = tok[MAX_PINS].all_filled;
		res.empty_res  = !tok[MAX_PINS].any_filled;
	end

endmodule

`default_nettype wire

/* verif/typed_slot_join_matcher_tb.sv */
// Self-checking testbench for the typed slot join matcher: pin table, socket fill and drain.
`timescale 1ns / 1ps

module typed_slot_join_matcher_tb;
	import tsjm_pkg::*;

	// Predicts each result from its request and compares what the block returns
	class pin_join_tracker;
		logic [1:0]  kind_tbl[TABLE_DEPTH];
		logic [15:0] type_tbl[TABLE_DEPTH];
		logic [15:0] sub_tbl[TABLE_DEPTH];
		logic [31:0] handle_tbl[TABLE_DEPTH];
		logic [63:0] filled;
		int unsigned pin_count;
		int unsigned sock_width;
		tsjm_res_t   pending_results[$];
		int unsigned mismatch_count;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				kind_tbl[i] = '0;
				type_tbl[i] = '0;
				sub_tbl[i] = '0;
				handle_tbl[i] = '0;
			end
			filled = '0;
			pin_count = 0;
			sock_width = 0;
			mismatch_count = 0;
		endfunction

		// Apply one request to the table and socket, return the outcome
		function tsjm_res_t join_outcome(tsjm_req_t r);
			tsjm_res_t o;
			logic [63:0] need;
			bit found;
			o = '0;
			found = 0;
			case (r.action)
				ACT_DEFINE: begin
					if (pin_count >= MAX_PINS_DEF || pin_count >= TABLE_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						kind_tbl[pin_count] = r.kind;
						type_tbl[pin_count] = r.type_code;
						sub_tbl[pin_count] = r.subtype_code;
						o.pin_hit = pin_count[5:0];
						pin_count++;
					end
				end
				ACT_NEWSOCK: begin
					filled = '0;
					sock_width = pin_count;
				end
				default: begin
					// lowest matching pin in the socket that is free (add) or filled (remove)
					o.status = ST_NOMATCH;
					for (int i = 0; i < sock_width && !found; i++) begin
						if (kind_tbl[i] == r.kind && type_tbl[i] == r.type_code &&
						    sub_tbl[i] == r.subtype_code) begin
							if (r.action == ACT_ADD && !filled[i]) begin
								filled[i] = 1'b1;
								handle_tbl[i] = r.handle;
								found = 1;
							end else if (r.action == ACT_REMOVE && filled[i]) begin
								filled[i] = 1'b0;
								o.handle_out = handle_tbl[i];
								found = 1;
							end
							if (found) begin
								o.status = ST_OK;
								o.pin_hit = i[5:0];
							end
						end
					end
				end
			endcase
			need = (sock_width >= 64) ? '1 : ((64'd1 << sock_width) - 64'd1);
			o.active = ((filled & need) == need);
			o.empty_res = ((filled & need) == 64'd0);
			return o;
		endfunction

		function void log_request(tsjm_req_t r);
			pending_results.push_back(join_outcome(r));
		endfunction

		function void check_result(tsjm_res_t got);
			tsjm_res_t exp;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				mismatch_count++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				mismatch_count++;
			end
			if (got.pin_hit !== exp.pin_hit) begin
				$error("pin_hit: expected %0d, got %0d", exp.pin_hit, got.pin_hit);
				mismatch_count++;
			end
			if (got.handle_out !== exp.handle_out) begin
				$error("handle_out: expected %h, got %h", exp.handle_out, got.handle_out);
				mismatch_count++;
			end
			if (got.active !== exp.active) begin
				$error("active: expected %0d, got %0d", exp.active, got.active);
				mismatch_count++;
			end
			if (got.empty_res !== exp.empty_res) begin
				$error("empty_res: expected %0d, got %0d", exp.empty_res, got.empty_res);
				mismatch_count++;
			end
		endfunction
	endclass

	localparam int PHASES = 9;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	tsjm_req_t req;
	logic      done;
	tsjm_res_t res;

	pin_join_tracker tracker;
	int unsigned     burst_left;

	// Patterns reused across defines so that several pins share one pattern
	logic [1:0]  pool_kind[8];
	logic [15:0] pool_type[8];
	logic [15:0] pool_sub[8];

	typed_slot_join_matcher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always #5 clk = ~clk;

	// Results cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(res);
	end

	function automatic tsjm_req_t mk_req(logic [1:0] a, logic [1:0] k, logic [15:0] t,
	                                     logic [15:0] s, logic [31:0] h);
		tsjm_req_t r;
		r.action = a;
		r.kind = k;
		r.type_code = t;
		r.subtype_code = s;
		r.handle = h;
		return r;
	endfunction

	// Random socket pin whose filled flag equals want, or -1
	function automatic int pick_pin(bit want);
		int cand[$];
		for (int i = 0; i < tracker.sock_width; i++)
			if (tracker.filled[i] == want)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// New pin pattern: mostly from the pool, sometimes fully random
	function automatic tsjm_req_t define_req();
		int p;
		if ($urandom_range(0, 9) < 7) begin
			p = $urandom_range(0, 7);
			return mk_req(ACT_DEFINE, pool_kind[p], pool_type[p], pool_sub[p], $urandom);
		end
		return mk_req(ACT_DEFINE, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
		              16'($urandom_range(0, 65535)), $urandom);
	endfunction

	// Add aimed at a free pin, or remove aimed at a filled one
	function automatic tsjm_req_t aimed_req(logic [1:0] a);
		int p;
		p = pick_pin(a == ACT_REMOVE);
		if (p < 0 && tracker.pin_count != 0)
			p = $urandom_range(0, tracker.pin_count - 1);
		if (p < 0)
			return mk_req(a, 2'($urandom_range(1, 2)), 16'($urandom_range(0, 65535)),
			              16'($urandom_range(0, 65535)), $urandom);
		return mk_req(a, tracker.kind_tbl[p], tracker.type_tbl[p], tracker.sub_tbl[p], $urandom);
	endfunction

	// Present one request, hold it until accepted, then maybe leave a gap
	task automatic send(tsjm_req_t item);
		int unsigned gap;
		req <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		tracker.log_request(item);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending until every outstanding request has its result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (tracker.pending_results.size() != 0);
	endtask

	// Run-time limit
	initial begin
		#2_000_000;
		$display("typed_slot_join_matcher verification failed");
		$finish;
	end

	initial begin
		int unsigned n_ops;
		int unsigned r;
		bit filling;
		tracker = new();
		burst_left = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		for (int j = 0; j < 8; j++) begin
			pool_kind[j] = (j == 6) ? 2'd0 : (j == 7) ? 2'd3 : 2'($urandom_range(1, 2));
			pool_type[j] = 16'($urandom_range(0, 65535));
			pool_sub[j] = 16'($urandom_range(0, 65535));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero-width socket, odd kinds, duplicates, pins beyond the socket
		send(mk_req(ACT_NEWSOCK, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_ADD, 2'd1, 16'h0000, 16'h0000, 32'h1111_1111));
		send(mk_req(ACT_REMOVE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_DEFINE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_DEFINE, 2'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
		send(mk_req(ACT_DEFINE, 2'd0, 16'h1234, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_DEFINE, 2'd3, 16'hFFFF, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_DEFINE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_ADD, 2'd1, 16'h0000, 16'h0000, 32'h2222_2222));
		send(mk_req(ACT_NEWSOCK, 2'd0, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_ADD, 2'd1, 16'h0000, 16'h0000, 32'hFFFF_FFFF));
		send(mk_req(ACT_ADD, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_ADD, 2'd1, 16'h0000, 16'h0000, 32'h3333_3333));
		send(mk_req(ACT_ADD, 2'd0, 16'h1234, 16'h0000, 32'hA5A5_A5A5));
		send(mk_req(ACT_ADD, 2'd3, 16'hFFFF, 16'h0000, 32'h5A5A_5A5A));
		send(mk_req(ACT_ADD, 2'd2, 16'hFFFF, 16'hFFFF, 32'h1234_5678));
		send(mk_req(ACT_DEFINE, 2'd2, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_ADD, 2'd2, 16'h0000, 16'h0000, 32'h4444_4444));
		send(mk_req(ACT_REMOVE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_REMOVE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_REMOVE, 2'd1, 16'h0000, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_REMOVE, 2'd2, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
		send(mk_req(ACT_REMOVE, 2'd0, 16'h1234, 16'h0000, 32'h0000_0000));
		send(mk_req(ACT_REMOVE, 2'd3, 16'hFFFF, 16'h0000, 32'h0000_0000));
		drain();

		// Random phases: grow the table, open a socket, fill it, then empty it
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				// run the table to full and past it
				while (tracker.pin_count < MAX_PINS_DEF)
					send(define_req());
				repeat (3) send(define_req());
			end else begin
				repeat ($urandom_range(1, 8)) send(define_req());
			end
			send(mk_req(ACT_NEWSOCK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
			            16'($urandom_range(0, 65535)), $urandom));
			n_ops = tracker.sock_width + $urandom_range(30, 50);
			for (int k = 0; k < n_ops; k++) begin
				filling = (k < (n_ops * 3) / 5);
				r = $urandom_range(0, 99);
				if (r < 4)
					send(define_req());
				else if (r < 5)
					send(mk_req(ACT_NEWSOCK, 2'($urandom_range(0, 3)),
					            16'($urandom_range(0, 65535)),
					            16'($urandom_range(0, 65535)), $urandom));
				else if (r < 15)
					send(mk_req($urandom_range(0, 1) ? ACT_ADD : ACT_REMOVE,
					            2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
					            16'($urandom_range(0, 65535)), $urandom));
				else if (($urandom_range(0, 4) != 0) == filling)
					send(aimed_req(ACT_ADD));
				else
					send(aimed_req(ACT_REMOVE));
			end
			if (ph % 3 == 1)
				drain();
		end

		// Wrap up: everything answered, then watch for strays
		drain();
		repeat (MAX_PINS_DEF + 8) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
			$display("typed_slot_join_matcher verification clean");
		else
			$display("typed_slot_join_matcher verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/tsjm_pkg.sv
rtl/tsjm_cell.sv
rtl/typed_slot_join_matcher.sv
verif/typed_slot_join_matcher_tb.sv
